// ----- rtl/core/dqe_pkg.sv -----
// shared types and constants for the double-ended queue
// no dependencies; imported by dqe_cell, double_ended_queue and the testbench
package dqe_pkg;

   // store geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // field widths
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_LEFT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_RIGHT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_LEFT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_RIGHT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CONTAINS   = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped;
      logic                      found;
      logic [STATUS_W-1:0]       status;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   // per-cell move control, load wins over shifts
   typedef struct packed {
      logic load;
      logic shift_r;
      logic shift_l;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/double_ended_queue.sv -----
// double-ended queue top level: cell chain, count register, result register
// depends on dqe_pkg and dqe_cell
// result is registered, presented in the cycle after the request transfer
// one request per cycle unless stalled, contains too; all cells compare at once
// reset: synchronous, clears the count (queue empty) and the result valid;
//   cell contents are not reset and are never read before being written
module double_ended_queue import dqe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // number of held entries; cell 0 is always the left end
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   // cell chain signals
   cell_ctrl_type             ctrl [DEPTH];
   logic signed [VALUE_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]          held;
   logic [DEPTH-1:0]          match;

   logic             accept;
   logic             full;
   logic             empty;
   logic [IDX_W-1:0] last_idx;

   // a new transfer can land whenever the result slot is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign last_idx = IDX_W'(cnt_ff - CNT_W'(1));

   // a cell holds a live entry when its position is below the count
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         held[i] = (cnt_ff > CNT_W'(i));
      end
   end

   // the chain of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_nb;
      logic signed [VALUE_W-1:0] right_nb;

      if (g == 0) begin : g_left_end
         assign left_nb = req_data.value;
      end else begin : g_left_mid
         assign left_nb = cell_data[g-1];
      end

      if (g == DEPTH - 1) begin : g_right_end
         assign right_nb = cell_data[g];
      end else begin : g_right_mid
         assign right_nb = cell_data[g+1];
      end

      dqe_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .held       (held[g]),
         .load_value (req_data.value),
         .left_data  (left_nb),
         .right_data (right_nb),
         .data       (cell_data[g]),
         .match      (match[g])
      );
   end

   // request decode: cell moves, count update, result fields
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i] = '0;
      end
      cnt_in             = cnt_ff;
      rsp_data_in.popped = '0;
      rsp_data_in.found  = 1'b0;
      rsp_data_in.status = ST_OK;

      case (req_data.kind)
         KIND_PUSH_LEFT: begin
            if (full) begin
               rsp_data_in.status = ST_FULL;
            end else if (accept) begin
               // everything moves one cell right, new value enters cell 0
               for (int i = 0; i < DEPTH; i++) begin
                  ctrl[i].shift_r = 1'b1;
               end
               ctrl[0].load = 1'b1;
               cnt_in       = cnt_ff + CNT_W'(1);
            end
         end
         KIND_PUSH_RIGHT: begin
            if (full) begin
               rsp_data_in.status = ST_FULL;
            end else if (accept) begin
               // first free cell takes the value
               for (int i = 0; i < DEPTH; i++) begin
                  ctrl[i].load = (cnt_ff == CNT_W'(i));
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         KIND_POP_LEFT: begin
            if (empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.popped = cell_data[0];
               if (accept) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     ctrl[i].shift_l = 1'b1;
                  end
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         KIND_POP_RIGHT: begin
            if (empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.popped = cell_data[last_idx];
               if (accept) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         KIND_CONTAINS: begin
            rsp_data_in.found = |match;
         end
         default: begin
            // unused kinds: no operation
         end
      endcase

      rsp_data_in.occupancy = OCC_W'(cnt_in);
   end

   // result valid: set on transfer in, cleared once the result is taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only on a transfer in
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // count never exceeds the store
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("held count above depth");

   // pop on empty reports the error and returns zero
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && (req_data.kind == KIND_POP_LEFT ||
                           req_data.kind == KIND_POP_RIGHT))
      |=> (rsp_data_ff.status == ST_EMPTY && rsp_data_ff.popped == '0))
      else $error("pop on empty not flagged");

   // accepted push into a non-full queue grows the count by one
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && (req_data.kind == KIND_PUSH_LEFT ||
                           req_data.kind == KIND_PUSH_RIGHT))
      |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("push did not grow the count");

   // count only moves on a transfer in
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(cnt_ff))
      else $error("count changed without a transfer");

   // a contains on an empty queue never matches
   a_found_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && req_data.kind == KIND_CONTAINS) |=> !rsp_data_ff.found)
      else $error("match reported on empty queue");
`endif

endmodule

// ----- rtl/core/dqe_cell.sv -----
// one storage cell of the deque chain: holds an entry, moves it to a neighbor
// and compares it against the search value
// depends on dqe_pkg
module dqe_cell import dqe_pkg::*; (
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic                      held,
   input  logic signed [VALUE_W-1:0] load_value,
   input  logic signed [VALUE_W-1:0] left_data,
   input  logic signed [VALUE_W-1:0] right_data,
   output logic signed [VALUE_W-1:0] data,
   output logic                      match
);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   always_comb begin
      if (ctrl.load) begin
         data_in = load_value;
      end else if (ctrl.shift_r) begin
         data_in = left_data;
      end else if (ctrl.shift_l) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = held && (data_ff == load_value);

endmodule

// ----- tb/sv/double_ended_queue_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for double_ended_queue: directed and random requests
// checked against a behavioral deque kept inside the bench
// depends on dqe_pkg and the double_ended_queue rtl
module double_ended_queue_tb;
   import dqe_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   // first kind code with no operation behind it
   localparam int KIND_UNUSED_LOW  = KIND_CONTAINS + 1;
   localparam int KIND_UNUSED_HIGH = (1 << KIND_W) - 1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // behavioral deque: circular store, leftmost slot and number held
   logic signed [VALUE_W-1:0] deque_slots [DEPTH];
   int deque_left  = 0;
   int deque_count = 0;

   // answers owed by the block, oldest first
   rsp_type owed_answers [$];

   int error_count = 0;
   int cycle_count = 0;
   // idling odds in percent per transfer (sender) and per cycle (receiver)
   int gap_pct     = 0;
   int stall_pct   = 0;
   int stall_run   = 0;

   double_ended_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("double_ended_queue_tb NOT OK");
         $finish;
      end
   end

   // apply one request to the behavioral deque and return the answer it owes
   function automatic rsp_type deque_apply(req_type r);
      rsp_type a;
      int      i;
      a = '0;
      case (r.kind)
         KIND_PUSH_LEFT: begin
            if (deque_count >= DEPTH) begin
               a.status = ST_FULL;
            end else begin
               deque_left = (deque_left + DEPTH - 1) % DEPTH;
               deque_slots[deque_left] = r.value;
               deque_count++;
            end
         end
         KIND_PUSH_RIGHT: begin
            if (deque_count >= DEPTH) begin
               a.status = ST_FULL;
            end else begin
               deque_slots[(deque_left + deque_count) % DEPTH] = r.value;
               deque_count++;
            end
         end
         KIND_POP_LEFT: begin
            if (deque_count == 0) begin
               a.status = ST_EMPTY;
            end else begin
               a.popped = deque_slots[deque_left];
               deque_left = (deque_left + 1) % DEPTH;
               deque_count--;
            end
         end
         KIND_POP_RIGHT: begin
            if (deque_count == 0) begin
               a.status = ST_EMPTY;
            end else begin
               a.popped = deque_slots[(deque_left + deque_count - 1) % DEPTH];
               deque_count--;
            end
         end
         KIND_CONTAINS: begin
            // only held slots are searched, so unwritten slots never matter
            for (i = 0; i < deque_count; i++) begin
               if (deque_slots[(deque_left + i) % DEPTH] == r.value) a.found = 1'b1;
            end
         end
         default: begin
         end
      endcase
      a.occupancy = OCC_W'(deque_count);
      return a;
   endfunction

   // one request transfer; valid stays high afterwards so back-to-back
   // transfers follow without a gap, callers lower it before waiting
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] value);
      req_type item;
      item.kind  = kind;
      item.value = value;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      owed_answers.push_back(deque_apply(item));
   endtask

   // sender holds off until every owed answer has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_answers.size() != 0) @(posedge clock);
   endtask

   // small values (-8 to 7) often so duplicates and hits are common, plus extremes and random values
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2, 3: return VALUE_W'($urandom_range(0, 15)) - 8;
         default: return $urandom();
      endcase
   endfunction

   // a value currently held, so contains queries hit
   function automatic logic signed [VALUE_W-1:0] pick_held_value();
      if (deque_count == 0) return pick_value();
      return deque_slots[(deque_left + $urandom_range(0, deque_count - 1)) % DEPTH];
   endfunction

   // random request stream; push_pct steers the fill level up or down
   task automatic run_random_items(input int count, input int push_pct);
      int                        roll;
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            kind = KIND_W'($urandom_range(KIND_UNUSED_LOW, KIND_UNUSED_HIGH));
         end else if (roll < 20) begin
            kind = KIND_CONTAINS;
         end else if ($urandom_range(0, 99) < push_pct) begin
            kind = $urandom_range(0, 1) ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT;
         end else begin
            kind = $urandom_range(0, 1) ? KIND_POP_RIGHT : KIND_POP_LEFT;
         end
         if (kind == KIND_CONTAINS && $urandom_range(0, 1)) value = pick_held_value();
         else value = pick_value();
         send_request(kind, value);
      end
   endtask

   // receiver side: stall bursts started at stall_pct odds
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         stall_run = 0;
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_run = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // every result transfer is matched against the oldest owed answer
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_answers.size() == 0) begin
            $error("result transfer with nothing owed: %h", rsp_data);
            error_count++;
         end else begin
            want = owed_answers.pop_front();
            if (rsp_data.popped !== want.popped) begin
               $error("popped: expected %0d, got %0d", want.popped, rsp_data.popped);
               error_count++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_data.found);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d",
                      want.occupancy, rsp_data.occupancy);
               error_count++;
            end
         end
      end
   end

   // pops and a query on the empty queue right after reset
   task automatic test_empty_queue();
      send_request(KIND_POP_LEFT, pick_value());
      send_request(KIND_POP_RIGHT, pick_value());
      send_request(KIND_CONTAINS, '0);
   endtask

   // unused kind codes must leave the queue alone
   task automatic test_unused_kinds();
      int k;
      for (k = KIND_UNUSED_LOW; k <= KIND_UNUSED_HIGH; k++) begin
         send_request(KIND_W'(k), $urandom());
      end
   endtask

   // fill from both ends across the wrap point, extremes last, then overflow, a query and a pop from each end
   task automatic test_fill_and_overflow();
      int n;
      for (n = 0; n < DEPTH - 4; n++) begin
         send_request(n[0] ? KIND_PUSH_LEFT : KIND_PUSH_RIGHT, $urandom());
      end
      send_request(KIND_PUSH_LEFT, -1);
      send_request(KIND_PUSH_RIGHT, '0);
      send_request(KIND_PUSH_LEFT, VALUE_MIN);
      send_request(KIND_PUSH_RIGHT, VALUE_MAX);
      // queue is full now, both pushes are dropped
      send_request(KIND_PUSH_LEFT, $urandom());
      send_request(KIND_PUSH_RIGHT, $urandom());
      send_request(KIND_CONTAINS, -1);
      send_request(KIND_POP_LEFT, $urandom());
      send_request(KIND_POP_RIGHT, $urandom());
   endtask

   // random walks at several fill biases and idling levels
   task automatic test_random_mix();
      gap_pct   = 30;
      stall_pct = 15;
      run_random_items(300, 50);
      run_random_items(300, 85);
      // full stop: nothing in flight before the drain-heavy walk
      wait_for_drain();
      run_random_items(300, 15);
      // a stretch with no idling on either side
      gap_pct   = 0;
      stall_pct = 0;
      run_random_items(150, 55);
      gap_pct   = 60;
      stall_pct = 40;
      run_random_items(300, 50);
   endtask

   // closing part at full rate, back-to-back transfers only
   task automatic test_no_idle();
      gap_pct   = 0;
      stall_pct = 0;
      run_random_items(200, 80);
      run_random_items(200, 30);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // mild idling during the directed part
      gap_pct   = 25;
      stall_pct = 20;
      test_empty_queue();
      test_unused_kinds();
      test_fill_and_overflow();
      test_random_mix();
      test_no_idle();
      wait_for_drain();
      // catch any stray result after the last owed one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("double_ended_queue_tb OK");
      end else begin
         $display("double_ended_queue_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/dqe_pkg.sv
rtl/core/dqe_cell.sv
rtl/core/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
